>>> hdl/ftct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftct_pkg
// Shared widths, constants and types of the tick count to calendar converter.
// ----------------------------------------------------------------------------
package ftct_pkg;

	localparam int TICK_W    = 64;
	localparam int DAY_W     = 24;          // quotient bits of the day divider
	localparam int DIV_SHIFT = 14;          // 864e9 = 2^14 * 52734375
	localparam int DIV_W     = 26;
	localparam int TOD_W     = DIV_W + DIV_SHIFT;
	localparam int SCALED_W  = TICK_W - 1 - DIV_SHIFT;   // count >> 14, count below 2^63
	localparam int SPLIT_W   = 24;          // low half of the scaled count
	localparam int LOP_W     = SPLIT_W + DAY_W;
	localparam int REM_W     = DIV_W + 1;   // remainder before the last correction
	localparam int KEEP_W    = DIV_SHIFT + REM_W;

	localparam logic [DIV_W-1:0] DAY_DIVISOR = 26'd52734375;
	localparam logic [DAY_W-1:0] DAY_RECIP   =
		DAY_W'((64'd1 << SCALED_W) / 64'(DAY_DIVISOR));

	localparam int DAY_LAT  = 4;
	localparam int CAL_LAT  = 16;
	localparam int CLK_LAT  = 6;
	localparam int CLK_PAD  = CAL_LAT - CLK_LAT;
	localparam int PIPE_LAT = DAY_LAT + CAL_LAT;

	// calendar constants; reciprocals are floor(2^s / d), s = operand width
	localparam logic [23:0] MARCH0_TO_1601 = 24'd584694;
	localparam logic [17:0] ERA_DAYS       = 18'd146097;
	localparam logic [6:0]  ERA_RECIP      = 7'((64'd1 << 24) / 64'(ERA_DAYS));
	localparam logic [2:0]  WEEK_LEN       = 3'd7;
	localparam logic [21:0] WEEK_RECIP     = 22'((64'd1 << 24) / 64'(WEEK_LEN));
	localparam logic [10:0] DAYS_4Y        = 11'd1460;
	localparam logic [7:0]  RECIP_4Y       = 8'((64'd1 << 18) / 64'(DAYS_4Y));
	localparam logic [15:0] DAYS_100Y      = 16'd36524;
	localparam logic [2:0]  RECIP_100Y     = 3'((64'd1 << 18) / 64'(DAYS_100Y));
	localparam logic [17:0] DAYS_400Y_M1   = 18'd146096;
	localparam logic [8:0]  YEAR_DAYS      = 9'd365;
	localparam logic [9:0]  RECIP_YEAR     = 10'((64'd1 << 18) / 64'(YEAR_DAYS));
	localparam logic [6:0]  CENTURY        = 7'd100;
	localparam logic [2:0]  RECIP_CENTURY  = 3'((64'd1 << 9) / 64'(CENTURY));
	localparam logic [7:0]  MONTH_SPAN     = 8'd153;
	localparam logic [3:0]  RECIP_SPAN     = 4'((64'd1 << 11) / 64'(MONTH_SPAN));
	localparam logic [2:0]  MP_SCALE       = 3'd5;
	localparam logic [1:0]  MP_BIAS        = 2'd2;
	localparam logic [8:0]  RECIP_FIVE     = 9'((64'd1 << 11) / 64'(MP_SCALE));
	localparam logic [6:0]  MPX_MUL        = 7'(64'(MP_SCALE) * 64'(RECIP_SPAN));
	localparam logic [4:0]  MPX_ADD        = 5'(64'(MP_BIAS) * 64'(RECIP_SPAN));
	localparam logic [15:0] DSUB_MUL       = 16'(64'(MONTH_SPAN) * 64'(RECIP_FIVE));
	localparam logic [9:0]  DSUB_ADD       = 10'(64'(MP_BIAS) * 64'(RECIP_FIVE));
	localparam logic [3:0]  MARCH_WRAP     = 4'd10;
	localparam logic [8:0]  ERA_YEARS      = 9'd400;

	// time-of-day constants
	localparam int          SEC_SHIFT  = 7;     // 1e7 = 2^7 * 78125
	localparam int          MS_SHIFT   = 4;     // 1e4 = 2^4 * 625
	localparam logic [16:0] SEC_DIV    = 17'd78125;
	localparam logic [16:0] SOD_RECIP  = 17'((64'd1 << 33) / 64'(SEC_DIV));
	localparam logic [9:0]  MS_DIV     = 10'd625;
	localparam logic [10:0] MS_RECIP   = 11'((64'd1 << 20) / 64'(MS_DIV));
	localparam logic [11:0] HOUR_SECS  = 12'd3600;
	localparam logic [5:0]  HOUR_RECIP = 6'((64'd1 << 17) / 64'(HOUR_SECS));
	localparam logic [5:0]  MIN_SECS   = 6'd60;
	localparam logic [6:0]  MIN_RECIP  = 7'((64'd1 << 12) / 64'(MIN_SECS));

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] millisecond;
	} hms_t;

endpackage
`default_nettype wire

>>> hdl/ftct_daydiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftct_daydiv
// Tick count / 864e9 into days and tick of day, four register stages.
// 864e9 = 2^14 * 52734375: the count >> 14 is multiplied by
// floor(2^49 / 52734375) in two halves, giving a quotient that is low by at
// most one; a compare and subtract on the remainder settles it.
// ----------------------------------------------------------------------------
module ftct_daydiv import ftct_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [TICK_W-2:0]   ticks,
	output logic [DAY_W-1:0]    days,
	output logic [TOD_W-1:0]    tod
);

	logic [SCALED_W-1:0]  scaled;
	logic [SCALED_W-1:0]  hi_n, est_n;
	logic [LOP_W-1:0]     lo_n;
	logic [REM_W-1:0]     rem_n;

	logic [SCALED_W-1:0]  hi_s1;
	logic [LOP_W-1:0]     lo_s1;
	logic [KEEP_W-1:0]    low_s1, low_s2;
	logic [DAY_W-1:0]     quo_s2, quo_s3, days_s4;
	logic [REM_W-1:0]     rem_s3;
	logic [DIV_SHIFT-1:0] frac_s3, frac_s4;
	logic [DIV_W-1:0]     rem_s4;

	always_comb begin
		scaled = ticks[TICK_W-2:DIV_SHIFT];
		hi_n   = SCALED_W'(scaled[SCALED_W-1:SPLIT_W]) * SCALED_W'(DAY_RECIP);
		lo_n   = LOP_W'(scaled[SPLIT_W-1:0]) * LOP_W'(DAY_RECIP);
		// full product >> 24; the quotient estimate is its top DAY_W bits
		est_n  = hi_s1 + SCALED_W'(lo_s1[LOP_W-1:SPLIT_W]);
		// remainder is below twice the divisor, so the low REM_W bits are exact
		rem_n  = low_s2[KEEP_W-1:DIV_SHIFT] - REM_W'(quo_s2) * REM_W'(DAY_DIVISOR);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1   <= hi_n;
			lo_s1   <= lo_n;
			low_s1  <= ticks[KEEP_W-1:0];

			quo_s2  <= est_n[SCALED_W-1:SCALED_W-DAY_W];
			low_s2  <= low_s1;

			quo_s3  <= quo_s2;
			rem_s3  <= rem_n;
			frac_s3 <= low_s2[DIV_SHIFT-1:0];

			if (rem_s3 >= REM_W'(DAY_DIVISOR)) begin
				days_s4 <= quo_s3 + DAY_W'(1);
				rem_s4  <= DIV_W'(rem_s3 - REM_W'(DAY_DIVISOR));
			end else begin
				days_s4 <= quo_s3;
				rem_s4  <= rem_s3[DIV_W-1:0];
			end
			frac_s4 <= frac_s3;
		end
	end

	assign days = days_s4;
	assign tod  = {rem_s4, frac_s4};

endmodule
`default_nettype wire

>>> hdl/ftct_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftct_split
// Day count to Gregorian date and weekday, tick of day to h:m:s.ms.
// Constant divisions by reciprocal multiply, then one correction step.
// ----------------------------------------------------------------------------
module ftct_split import ftct_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DAY_W-1:0] days,
	input  logic [TOD_W-1:0] tod,
	output logic [14:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [2:0]       weekday,
	output hms_t             clock
);

	// ---------------- calendar path ----------------
	logic [23:0] z_s1, wx_s1, z_s2, wx_s2;
	logic [6:0]  era0_s2;
	logic [21:0] wk0_s2;
	logic [6:0]  era_s3, era_s4, era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [6:0]  era_s11, era_s12, era_s13, era_s14, era_s15;
	logic [2:0]  wd_s3, wd_s4, wd_s5, wd_s6, wd_s7, wd_s8, wd_s9, wd_s10;
	logic [2:0]  wd_s11, wd_s12, wd_s13, wd_s14, wd_s15, wd_s16;
	logic [17:0] doe_s3, doe_s4, doe_s5, doe_s6, doe_s7, doe_s8, doe_s9, doe_s10;
	logic [7:0]  a0_s4, a_s5;
	logic [2:0]  b0_s4, b_s5;
	logic        c_s5;
	logic [17:0] t_s6, t_s7;
	logic [9:0]  y0_s7;
	logic [8:0]  yoe_s8, yoe_s9, yoe_s10, yoe_s11, yoe_s12, yoe_s13, yoe_s14, yoe_s15;
	logic [2:0]  h0_s9, hund_s10;
	logic [8:0]  doy_s11, doy_s12, doy_s13, doy_s14, doy_s15;
	logic [3:0]  m0_s12, mp_s13, mp_s14, mp_s15;
	logic [8:0]  d0_s14, dq_s15;
	logic [14:0] year_s16;
	logic [3:0]  month_s16;
	logic [4:0]  day_s16;

	logic [30:0] era_p;
	logic [45:0] wk_p;
	logic [24:0] era_m, era_r, wk_m, wk_r;
	logic [25:0] a_p;
	logic [20:0] b_p;
	logic [18:0] a_r, b_r;
	logic [17:0] t_n;
	logic [27:0] y_p;
	logic [18:0] y_r;
	logic [9:0]  yoe_n;
	logic [11:0] h_p;
	logic [9:0]  h_r;
	logic [17:0] base_n, doy_n;
	logic [15:0] m_p;
	logic [11:0] mx_n, m_r;
	logic [19:0] d_p;
	logic [10:0] du_n, d_r;
	logic [9:0]  day_n;
	logic [3:0]  mon_n;
	logic [14:0] year_n;

	always_comb begin
		era_p  = 31'(z_s1) * 31'(ERA_RECIP);
		wk_p   = 46'(wx_s1) * 46'(WEEK_RECIP);
		era_m  = 25'(era0_s2) * 25'(ERA_DAYS);
		era_r  = 25'(z_s2) - era_m;
		wk_m   = 25'(wk0_s2) * 25'(WEEK_LEN);
		wk_r   = 25'(wx_s2) - wk_m;
		a_p    = 26'(doe_s3) * 26'(RECIP_4Y);
		b_p    = 21'(doe_s3) * 21'(RECIP_100Y);
		a_r    = 19'(doe_s4) - 19'(a0_s4) * 19'(DAYS_4Y);
		b_r    = 19'(doe_s4) - 19'(b0_s4) * 19'(DAYS_100Y);
		t_n    = doe_s5 - 18'(a_s5) + 18'(b_s5) - 18'(c_s5);
		y_p    = 28'(t_s6) * 28'(RECIP_YEAR);
		y_r    = 19'(t_s7) - 19'(y0_s7) * 19'(YEAR_DAYS);
		yoe_n  = (y_r >= 19'(YEAR_DAYS)) ? y0_s7 + 10'd1 : y0_s7;
		h_p    = 12'(yoe_s8) * 12'(RECIP_CENTURY);
		h_r    = 10'(yoe_s9) - 10'(h0_s9) * 10'(CENTURY);
		base_n = 18'(yoe_s10) * 18'(YEAR_DAYS) + 18'(yoe_s10[8:2]) - 18'(hund_s10);
		doy_n  = doe_s10 - base_n;
		// (5*doy + 2) * recip folded into one constant multiply
		m_p    = 16'(doy_s11) * 16'(MPX_MUL) + 16'(MPX_ADD);
		mx_n   = 12'(doy_s12) * 12'(MP_SCALE) + 12'(MP_BIAS);
		m_r    = mx_n - 12'(m0_s12) * 12'(MONTH_SPAN);
		d_p    = 20'(mp_s13) * 20'(DSUB_MUL) + 20'(DSUB_ADD);
		du_n   = 11'(mp_s14) * 11'(MONTH_SPAN) + 11'(MP_BIAS);
		d_r    = du_n - 11'(d0_s14) * 11'(MP_SCALE);
		day_n  = 10'(doy_s15) - 10'(dq_s15) + 10'd1;
		mon_n  = (mp_s15 >= MARCH_WRAP) ? mp_s15 - 4'd9 : mp_s15 + 4'd3;
		// Jan and Feb belong to the next year of a March-based year
		year_n = 15'(yoe_s15) + 15'(era_s15) * 15'(ERA_YEARS)
			+ 15'(mp_s15 >= MARCH_WRAP);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1     <= days + MARCH0_TO_1601;
			wx_s1    <= days + 24'd1;

			z_s2     <= z_s1;
			wx_s2    <= wx_s1;
			era0_s2  <= era_p[30:24];
			wk0_s2   <= wk_p[45:24];

			if (era_r >= 25'(ERA_DAYS)) begin
				era_s3 <= era0_s2 + 7'd1;
				doe_s3 <= 18'(era_r - 25'(ERA_DAYS));
			end else begin
				era_s3 <= era0_s2;
				doe_s3 <= era_r[17:0];
			end
			wd_s3    <= (wk_r >= 25'(WEEK_LEN)) ? 3'(wk_r - 25'(WEEK_LEN)) : wk_r[2:0];

			a0_s4    <= a_p[25:18];
			b0_s4    <= b_p[20:18];
			doe_s4   <= doe_s3;
			era_s4   <= era_s3;
			wd_s4    <= wd_s3;

			a_s5     <= (a_r >= 19'(DAYS_4Y)) ? a0_s4 + 8'd1 : a0_s4;
			b_s5     <= (b_r >= 19'(DAYS_100Y)) ? b0_s4 + 3'd1 : b0_s4;
			c_s5     <= (doe_s4 >= DAYS_400Y_M1);
			doe_s5   <= doe_s4;
			era_s5   <= era_s4;
			wd_s5    <= wd_s4;

			t_s6     <= t_n;
			doe_s6   <= doe_s5;
			era_s6   <= era_s5;
			wd_s6    <= wd_s5;

			y0_s7    <= y_p[27:18];
			t_s7     <= t_s6;
			doe_s7   <= doe_s6;
			era_s7   <= era_s6;
			wd_s7    <= wd_s6;

			yoe_s8   <= yoe_n[8:0];
			doe_s8   <= doe_s7;
			era_s8   <= era_s7;
			wd_s8    <= wd_s7;

			h0_s9    <= h_p[11:9];
			yoe_s9   <= yoe_s8;
			doe_s9   <= doe_s8;
			era_s9   <= era_s8;
			wd_s9    <= wd_s8;

			hund_s10 <= (h_r >= 10'(CENTURY)) ? h0_s9 + 3'd1 : h0_s9;
			yoe_s10  <= yoe_s9;
			doe_s10  <= doe_s9;
			era_s10  <= era_s9;
			wd_s10   <= wd_s9;

			doy_s11  <= doy_n[8:0];
			yoe_s11  <= yoe_s10;
			era_s11  <= era_s10;
			wd_s11   <= wd_s10;

			m0_s12   <= m_p[14:11];
			doy_s12  <= doy_s11;
			yoe_s12  <= yoe_s11;
			era_s12  <= era_s11;
			wd_s12   <= wd_s11;

			mp_s13   <= (m_r >= 12'(MONTH_SPAN)) ? m0_s12 + 4'd1 : m0_s12;
			doy_s13  <= doy_s12;
			yoe_s13  <= yoe_s12;
			era_s13  <= era_s12;
			wd_s13   <= wd_s12;

			d0_s14   <= d_p[19:11];
			mp_s14   <= mp_s13;
			doy_s14  <= doy_s13;
			yoe_s14  <= yoe_s13;
			era_s14  <= era_s13;
			wd_s14   <= wd_s13;

			dq_s15   <= (d_r >= 11'(MP_SCALE)) ? d0_s14 + 9'd1 : d0_s14;
			mp_s15   <= mp_s14;
			doy_s15  <= doy_s14;
			yoe_s15  <= yoe_s14;
			era_s15  <= era_s14;
			wd_s15   <= wd_s14;

			year_s16  <= year_n;
			month_s16 <= mon_n;
			day_s16   <= day_n[4:0];
			wd_s16    <= wd_s15;
		end
	end

	assign year         = year_s16;
	assign month        = month_s16;
	assign day_of_month = day_s16;
	assign weekday      = wd_s16;

	// ---------------- time-of-day path ----------------
	logic [16:0]      sod0_s1, sod_s2, sod_s3;
	logic [TOD_W-1:0] tod_s1;
	logic [19:0]      msx_s2, msx_s3;
	logic [10:0]      ms0_s3;
	logic [5:0]       hr0_s3;
	logic [9:0]       ms_s4, ms_s5;
	logic [4:0]       hr_s4, hr_s5;
	logic [11:0]      rs_s4, rs_s5;
	logic [6:0]       mi0_s5;
	hms_t             hms_s6;
	hms_t             hms_dly [CLK_PAD];

	logic [49:0] s_p;
	logic [33:0] s_m, s_r;
	logic [16:0] srem_n;
	logic [30:0] ms_p;
	logic [22:0] hr_p;
	logic [20:0] ms_r;
	logic [10:0] ms_n;
	logic [17:0] hr_r;
	logic [5:0]  hr_n;
	logic [18:0] mi_p;
	logic [12:0] mi_r;
	logic [6:0]  mi_n;

	always_comb begin
		s_p    = 50'(tod[TOD_W-1:SEC_SHIFT]) * 50'(SOD_RECIP);
		s_m    = 34'(sod0_s1) * 34'(SEC_DIV);
		s_r    = 34'(tod_s1[TOD_W-1:SEC_SHIFT]) - s_m;
		srem_n = (s_r >= 34'(SEC_DIV)) ? 17'(s_r - 34'(SEC_DIV)) : s_r[16:0];
		ms_p   = 31'(msx_s2) * 31'(MS_RECIP);
		hr_p   = 23'(sod_s2) * 23'(HOUR_RECIP);
		ms_r   = 21'(msx_s3) - 21'(ms0_s3) * 21'(MS_DIV);
		ms_n   = (ms_r >= 21'(MS_DIV)) ? ms0_s3 + 11'd1 : ms0_s3;
		hr_r   = 18'(sod_s3) - 18'(hr0_s3) * 18'(HOUR_SECS);
		hr_n   = (hr_r >= 18'(HOUR_SECS)) ? hr0_s3 + 6'd1 : hr0_s3;
		mi_p   = 19'(rs_s4) * 19'(MIN_RECIP);
		mi_r   = 13'(rs_s5) - 13'(mi0_s5) * 13'(MIN_SECS);
		mi_n   = (mi_r >= 13'(MIN_SECS)) ? mi0_s5 + 7'd1 : mi0_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sod0_s1 <= s_p[49:33];
			tod_s1  <= tod;

			sod_s2  <= (s_r >= 34'(SEC_DIV)) ? sod0_s1 + 17'd1 : sod0_s1;
			// (sub-second ticks) >> 4, ready for the divide by 625
			msx_s2  <= {srem_n, tod_s1[SEC_SHIFT-1:MS_SHIFT]};

			ms0_s3  <= ms_p[30:20];
			hr0_s3  <= hr_p[22:17];
			msx_s3  <= msx_s2;
			sod_s3  <= sod_s2;

			ms_s4   <= ms_n[9:0];
			hr_s4   <= hr_n[4:0];
			rs_s4   <= (hr_r >= 18'(HOUR_SECS)) ? 12'(hr_r - 18'(HOUR_SECS)) : hr_r[11:0];

			mi0_s5  <= mi_p[18:12];
			rs_s5   <= rs_s4;
			ms_s5   <= ms_s4;
			hr_s5   <= hr_s4;

			hms_s6.hour        <= hr_s5;
			hms_s6.minute      <= mi_n[5:0];
			hms_s6.second      <= (mi_r >= 13'(MIN_SECS)) ? 6'(mi_r - 13'(MIN_SECS)) : mi_r[5:0];
			hms_s6.millisecond <= ms_s5;

			// align with the longer calendar path
			hms_dly[0] <= hms_s6;
			for (int k = 1; k < CLK_PAD; k++) begin
				hms_dly[k] <= hms_dly[k-1];
			end
		end
	end

	assign clock = hms_dly[CLK_PAD-1];

endmodule
`default_nettype wire

>>> hdl/filetime_to_calendar_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// filetime_to_calendar_time
// Converts a 64-bit count of 100 ns ticks since 1601-01-01 UTC into
// Gregorian date, weekday and time of day.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | tick_valid / tick_ready    | tick_count
//  result   | result_valid / result_ready| invalid, year, month, day_of_month,
//           |                            | weekday, hour, minute, second,
//           |                            | millisecond
//
// One transaction per clock while the output is not held; 20 register
// stages: 4 stages of the reciprocal day divider, then 16 stages of
// calendar arithmetic.
// Reset clears the stage valid bits only.
// A result held on the output freezes the whole pipeline; tick_ready is low
// only while result_valid is high and result_ready is low.
// ----------------------------------------------------------------------------
module filetime_to_calendar_time import ftct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  logic [TICK_W-1:0] tick_count,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              invalid,
	output logic [14:0]       year,
	output logic [3:0]        month,
	output logic [4:0]        day_of_month,
	output logic [2:0]        weekday,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second,
	output logic [9:0]        millisecond
);

	logic             en;
	logic             vld_s [PIPE_LAT];
	logic             inv_s [PIPE_LAT];
	logic [DAY_W-1:0] days;
	logic [TOD_W-1:0] tod;
	logic [14:0]      cal_year;
	logic [3:0]       cal_month;
	logic [4:0]       cal_day;
	logic [2:0]       cal_wd;
	hms_t             clock;

	assign en         = !vld_s[PIPE_LAT-1] || result_ready;
	assign tick_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= tick_valid;
			for (int k = 1; k < PIPE_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s[0] <= tick_count[TICK_W-1];
			for (int k = 1; k < PIPE_LAT; k++) begin
				inv_s[k] <= inv_s[k-1];
			end
		end
	end

	ftct_daydiv u_daydiv (
		.clk   (clk),
		.en    (en),
		.ticks (tick_count[TICK_W-2:0]),
		.days  (days),
		.tod   (tod)
	);

	ftct_split u_split (
		.clk          (clk),
		.en           (en),
		.days         (days),
		.tod          (tod),
		.year         (cal_year),
		.month        (cal_month),
		.day_of_month (cal_day),
		.weekday      (cal_wd),
		.clock        (clock)
	);

	// out-of-range counts raise invalid and report zeros in every other field
	assign result_valid = vld_s[PIPE_LAT-1];
	assign invalid      = inv_s[PIPE_LAT-1];
	assign year         = invalid ? '0 : cal_year;
	assign month        = invalid ? '0 : cal_month;
	assign day_of_month = invalid ? '0 : cal_day;
	assign weekday      = invalid ? '0 : cal_wd;
	assign hour         = invalid ? '0 : clock.hour;
	assign minute       = invalid ? '0 : clock.minute;
	assign second       = invalid ? '0 : clock.second;
	assign millisecond  = invalid ? '0 : clock.millisecond;

endmodule
`default_nettype wire

>>> dv/tb_filetime_to_calendar_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_filetime_to_calendar_time
// Drives tick counts through the converter with random gaps on the input and
// random stalls on the result side, predicts each date and time of day, and
// checks every result field in order of arrival.
// ----------------------------------------------------------------------------
module tb_filetime_to_calendar_time;

	localparam logic [63:0] DAY_TICKS     = 64'd864000000000;
	localparam logic [63:0] TICKS_PER_SEC = 64'd10000000;
	localparam logic [63:0] TICKS_PER_MS  = 64'd10000;
	localparam logic [63:0] EPOCH_OFFSET  = 64'd584694;   // days 0000-03-01 to 1601-01-01
	localparam logic [63:0] DAYS_IN_ERA   = 64'd146097;
	localparam logic [63:0] LAST_DAY      = 64'd10675199; // last whole day below 2^63
	localparam int          N_RANDOM      = 900;
	localparam int          IDLE_PCT      = 15;
	localparam int          QUIET_LO      = 200;
	localparam int          QUIET_HI      = 350;
	localparam int          HOLD_AT       = 400;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          STALL_LIMIT   = 4000;

	typedef struct packed {
		logic        invalid;
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millisecond;
	} calendar_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      tick_valid = 1'b0;
	logic                      tick_ready;
	logic [ftct_pkg::TICK_W-1:0] tick_count = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic                      invalid;
	logic [14:0]               year;
	logic [3:0]                month;
	logic [4:0]                day_of_month;
	logic [2:0]                weekday;
	logic [4:0]                hour;
	logic [5:0]                minute;
	logic [5:0]                second;
	logic [9:0]                millisecond;

	logic [63:0] pending_ticks[$];
	calendar_t   expected_dates[$];
	int          n_sent = 0;
	int          n_checked = 0;
	int          n_errors = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          stall_cycles = 0;

	filetime_to_calendar_time DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick_count   (tick_count),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.invalid      (invalid),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.millisecond  (millisecond)
	);

	always #4 clk = ~clk;

	// civil-from-days on a March-based year, 400-year eras
	function automatic calendar_t calendar_of(input logic [63:0] ticks);
		calendar_t   c;
		logic [63:0] days, tod, sod, frac, z, era, doe, yoe, doy, mp, yr, mo, dd;
		c = '0;
		if (ticks[63]) begin
			c.invalid = 1'b1;
			return c;
		end
		days = ticks / DAY_TICKS;
		tod  = ticks % DAY_TICKS;
		sod  = tod / TICKS_PER_SEC;
		frac = tod % TICKS_PER_SEC;
		z    = days + EPOCH_OFFSET;
		era  = z / DAYS_IN_ERA;
		doe  = z - era * DAYS_IN_ERA;
		yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp   = (5 * doy + 2) / 153;
		yr   = yoe + era * 400;
		mo   = (mp < 10) ? mp + 3 : mp - 9;
		dd   = doy - (153 * mp + 2) / 5 + 1;
		if (mo <= 2)
			yr = yr + 1;
		c.year         = yr[14:0];
		c.month        = mo[3:0];
		c.day_of_month = dd[4:0];
		c.weekday      = 3'((days + 1) % 7);
		c.hour         = 5'(sod / 3600);
		c.minute       = 6'((sod % 3600) / 60);
		c.second       = 6'(sod % 60);
		c.millisecond  = 10'(frac / TICKS_PER_MS);
		return c;
	endfunction

	function automatic logic [63:0] at_day(input logic [63:0] days, input logic [63:0] tod);
		return days * DAY_TICKS + tod;
	endfunction

	function automatic logic [63:0] random_tick();
		logic [63:0] raw;
		logic [63:0] days;
		raw  = {$urandom, $urandom};
		days = 64'($urandom_range(0, int'(LAST_DAY) - 1));
		case ($urandom_range(0, 9))
			0, 1, 2:    return raw;                             // half of these invalid
			3, 4, 5, 6: return {1'b0, raw[62:0]};
			7: begin
				// hug a day boundary
				if ($urandom_range(0, 1))
					return at_day(days, 64'($urandom_range(0, 20)));
				return at_day(days, DAY_TICKS - 1 - 64'($urandom_range(0, 20)));
			end
			8:       return at_day(64'($urandom_range(0, 200000)), raw % DAY_TICKS);
			default: return 64'h7fff_ffff_ffff_ffff - 64'($urandom);
		endcase
	endfunction

	task automatic report(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			n_errors++;
		end
	endtask

	// sender: keeps valid and payload steady until the transaction completes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
			tick_count <= '0;
		end else begin
			if (tick_valid && tick_ready) begin
				expected_dates.push_back(calendar_of(tick_count));
				n_sent++;
			end
			if (!tick_valid || tick_ready) begin
				if (pending_ticks.size() != 0 &&
				    ((n_sent >= QUIET_LO && n_sent < QUIET_HI) ||
				     $urandom_range(0, 99) >= IDLE_PCT)) begin
					tick_valid <= 1'b1;
					tick_count <= pending_ticks.pop_front();
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back up the pipeline
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (!hold_done && n_checked >= HOLD_AT) begin
			hold_done    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= (n_checked >= QUIET_LO && n_checked < QUIET_HI) ||
			                $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		calendar_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual year %0d month %0d",
				         $time, year, month);
				n_errors++;
			end else begin
				want = expected_dates.pop_front();
				report("invalid", want.invalid, invalid);
				report("year", want.year, year);
				report("month", want.month, month);
				report("day_of_month", want.day_of_month, day_of_month);
				report("weekday", want.weekday, weekday);
				report("hour", want.hour, hour);
				report("minute", want.minute, minute);
				report("second", want.second, second);
				report("millisecond", want.millisecond, millisecond);
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_valid && tick_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] max_valid;
		max_valid = 64'h7fff_ffff_ffff_ffff;

		// field extremes, day and millisecond edges, leap rules, invalid range
		pending_ticks.push_back(64'd0);
		pending_ticks.push_back(64'd9999);
		pending_ticks.push_back(64'd10000);
		pending_ticks.push_back(DAY_TICKS - 1);
		pending_ticks.push_back(DAY_TICKS);
		pending_ticks.push_back(at_day(64'd1154, 64'd0));            // 1604-02-29
		pending_ticks.push_back(at_day(64'd36217, DAY_TICKS - 1));   // 1700-02-28 end
		pending_ticks.push_back(at_day(64'd36218, 64'd0));           // 1700-03-01
		pending_ticks.push_back(at_day(64'd145791, 64'd43210987654)); // 2000-03-01
		pending_ticks.push_back(at_day(64'd146096, DAY_TICKS - 1));  // 2000-12-31, last day of the 400 years from 1601
		pending_ticks.push_back(max_valid);
		pending_ticks.push_back(64'h8000_0000_0000_0000);
		pending_ticks.push_back(64'hffff_ffff_ffff_ffff);
		pending_ticks.push_back(64'h8000_0000_0000_0000 | {$urandom, $urandom});
		pending_ticks.push_back(64'h5555_5555_5555_5555);
		pending_ticks.push_back(64'h2aaa_aaaa_aaaa_aaaa);
		for (int d = 0; d < 7; d++)
			pending_ticks.push_back(at_day(64'(d), 64'($urandom) % DAY_TICKS));
		for (int i = 0; i < N_RANDOM; i++)
			pending_ticks.push_back(random_tick());

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ticks.size() != 0 || tick_valid)
			@(posedge clk);
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (ftct_pkg::PIPE_LAT + 10) @(posedge clk);

		if (n_errors == 0 && expected_dates.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
